### sv/matrix3x3_add_multiply_defines.svh
// ---------------------------------------------------------------------------
// matrix3x3_add_multiply_defines
// Assertion macros shared by the matrix add/multiply modules.
// ---------------------------------------------------------------------------
`ifndef MATRIX3X3_ADD_MULTIPLY_DEFINES_SVH
`define MATRIX3X3_ADD_MULTIPLY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MXAM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MXAM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/mxam_pkg.sv
// ---------------------------------------------------------------------------
// mxam_pkg
// Sizes, payload types and control structs of the matrix add/multiply block.
// ---------------------------------------------------------------------------
package mxam_pkg;

   // matrix geometry and element width
   localparam int DIM        = 3;
   localparam int ELEM_WIDTH = 16;
   localparam int CELLS      = DIM * DIM;
   localparam int CELL_AW    = $clog2(CELLS);
   localparam int IDX_W      = $clog2(DIM);
   localparam int LOAD_W     = $clog2(2 * CELLS);
   localparam int MUL_W      = 2 * ELEM_WIDTH;

   // fixed port field widths
   localparam int ELEMENT_W = 16;
   localparam int ROW_W     = 2;
   localparam int COL_W     = 2;
   localparam int SUM_W     = 17;
   localparam int PROD_W    = 33;

   typedef logic signed [ELEMENT_W-1:0]  element_type;
   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic        [ROW_W-1:0]      row_type;
   typedef logic        [COL_W-1:0]      col_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [MUL_W-1:0]      mul_type;
   typedef logic        [CELL_AW-1:0]    addr_type;
   typedef logic        [IDX_W-1:0]      idx_type;

   // sequencer to datapath
   typedef struct packed {
      logic     wr_en;
      logic     wr_sel_b;
      addr_type wr_addr;
      elem_type wr_data;
      logic     issue;
      logic     first;
      logic     last_k;
      logic     last_entry;
      idx_type  row;
      idx_type  col;
      addr_type a_k_addr;
      addr_type b_k_addr;
      addr_type rc_addr;
   } ctl_type;

   // datapath to sequencer
   typedef struct packed {
      logic busy;
      logic out_free;
   } stat_type;

   // row-major cell address
   function automatic addr_type cell_index(idx_type r, idx_type c);
      cell_index = CELL_AW'(r) * CELL_AW'(DIM) + CELL_AW'(c);
   endfunction

   // low ELEM_WIDTH bits of the port element, sign-extended or cut
   function automatic elem_type widen_element(element_type e);
      widen_element = ELEM_WIDTH'(e);
   endfunction

endpackage

### sv/mxam_if.sv
// ---------------------------------------------------------------------------
// mxam_if
// Valid/ready channel interfaces for matrix elements and result entries.
// ---------------------------------------------------------------------------
interface mxam_req_if;
   logic                  valid;
   logic                  ready;
   mxam_pkg::element_type element;

   modport source (output valid, output element, input ready);
   modport sink   (input valid, input element, output ready);
endinterface

interface mxam_rsp_if;
   logic               valid;
   logic               ready;
   mxam_pkg::row_type  row;
   mxam_pkg::col_type  column;
   mxam_pkg::sum_type  sum_entry;
   mxam_pkg::prod_type product_entry;
   logic               last;

   modport source (output valid, output row, output column, output sum_entry,
                   output product_entry, output last, input ready);
   modport sink   (input valid, input row, input column, input sum_entry,
                   input product_entry, input last, output ready);
endinterface

### sv/mxam_dp.sv
// ---------------------------------------------------------------------------
// mxam_dp
// Matrix stores, shared multiply-accumulate unit and result register.
// ---------------------------------------------------------------------------
`include "matrix3x3_add_multiply_defines.svh"

module mxam_dp (
   input  logic              clock,
   input  logic              reset,
   input  mxam_pkg::ctl_type ctl,
   output mxam_pkg::stat_type stat,
   mxam_rsp_if.source        rsp
);
   import mxam_pkg::*;

   elem_type a_mem [CELLS];
   elem_type b_mem [CELLS];

   // read stage
   elem_type a_k_ff, b_k_ff, a_rc_ff, b_rc_ff;
   logic     v1_ff, first1_ff, last_k1_ff, last_e1_ff;
   idx_type  row1_ff, col1_ff;

   // multiply stage
   mul_type  prod_ff;
   sum_type  sum_ff;
   logic     v2_ff, first2_ff, last_k2_ff, last_e2_ff;
   idx_type  row2_ff, col2_ff;

   // accumulate stage and result register
   prod_type acc_ff, acc_in;
   logic     out_load;
   logic     rsp_valid_ff, rsp_valid_in;
   row_type  rsp_row_ff;
   col_type  rsp_col_ff;
   sum_type  rsp_sum_ff;
   prod_type rsp_prod_ff;
   logic     rsp_last_ff;

   // element writes
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         if (ctl.wr_sel_b) begin
            b_mem[ctl.wr_addr] <= ctl.wr_data;
         end else begin
            a_mem[ctl.wr_addr] <= ctl.wr_data;
         end
      end
   end

   // registered reads, two ports per store
   always_ff @(posedge clock) begin
      a_k_ff     <= a_mem[ctl.a_k_addr];
      a_rc_ff    <= a_mem[ctl.rc_addr];
      b_k_ff     <= b_mem[ctl.b_k_addr];
      b_rc_ff    <= b_mem[ctl.rc_addr];
      first1_ff  <= ctl.first;
      last_k1_ff <= ctl.last_k;
      last_e1_ff <= ctl.last_entry;
      row1_ff    <= ctl.row;
      col1_ff    <= ctl.col;
   end

   // multiply, and elementwise sum on the first step of an entry
   always_ff @(posedge clock) begin
      prod_ff    <= a_k_ff * b_k_ff;
      first2_ff  <= first1_ff;
      last_k2_ff <= last_k1_ff;
      last_e2_ff <= last_e1_ff;
      row2_ff    <= row1_ff;
      col2_ff    <= col1_ff;
      if (v1_ff && first1_ff) begin
         sum_ff <= SUM_W'(a_rc_ff) + SUM_W'(b_rc_ff);
      end
   end

   // accumulate
   assign acc_in   = first2_ff ? PROD_W'(prod_ff) : acc_ff + PROD_W'(prod_ff);
   assign out_load = v2_ff && last_k2_ff;

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.issue;
         v2_ff <= v1_ff;
      end
   end

   // result register
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_row_ff  <= ROW_W'(row2_ff);
         rsp_col_ff  <= COL_W'(col2_ff);
         rsp_sum_ff  <= sum_ff;
         rsp_prod_ff <= acc_in;
         rsp_last_ff <= last_e2_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.row           = rsp_row_ff;
   assign rsp.column        = rsp_col_ff;
   assign rsp.sum_entry     = rsp_sum_ff;
   assign rsp.product_entry = rsp_prod_ff;
   assign rsp.last          = rsp_last_ff;

   assign stat.busy     = v1_ff || v2_ff;
   assign stat.out_free = !rsp_valid_ff || rsp.ready;

   // a finished entry never overwrites a result still waiting
   `MXAM_ASSERT_IMPL(a_no_overwrite, clock, reset, out_load,
      !rsp_valid_ff || rsp.ready, "result register overwritten")
   // multiply stage only holds work that came through the read stage
   `MXAM_ASSERT_NEXT(a_stage_order, clock, reset, !v1_ff, !v2_ff,
      "multiply stage valid without read stage")
   // final transfer of a batch is the bottom-right entry
   `MXAM_ASSERT_IMPL(a_last_corner, clock, reset, rsp_valid_ff && rsp_last_ff,
      rsp_row_ff == ROW_W'(DIM - 1) && rsp_col_ff == COL_W'(DIM - 1),
      "last flag on wrong entry")

endmodule

### sv/mxam_seq.sv
// ---------------------------------------------------------------------------
// mxam_seq
// Load counter and row/column/step sequencer for the shared MAC unit.
// ---------------------------------------------------------------------------
`include "matrix3x3_add_multiply_defines.svh"

module mxam_seq (
   input  logic                clock,
   input  logic                reset,
   mxam_req_if.sink            req,
   input  mxam_pkg::stat_type  stat,
   output mxam_pkg::ctl_type   ctl
);
   import mxam_pkg::*;

   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_CALC = 1'b1;

   localparam logic [LOAD_W-1:0] LOAD_LAST  = LOAD_W'(2 * CELLS - 1);
   localparam logic [LOAD_W-1:0] LOAD_CELLS = LOAD_W'(CELLS);
   localparam idx_type           IDX_LAST   = IDX_W'(DIM - 1);

   logic              state_ff, state_in;
   logic [LOAD_W-1:0] load_cnt_ff, load_cnt_in;
   idx_type           row_ff, row_in;
   idx_type           col_ff, col_in;
   idx_type           k_ff, k_in;
   logic              accept;
   logic              issue;
   logic              last_k;
   logic              last_entry;

   assign req.ready  = (state_ff == ST_LOAD);
   assign accept     = req.valid && req.ready;
   assign last_k     = (k_ff == IDX_LAST);
   assign last_entry = (row_ff == IDX_LAST) && (col_ff == IDX_LAST);

   // a new entry starts only on an empty pipe with room for its result
   assign issue = (state_ff == ST_CALC) &&
                  ((k_ff != '0) || (!stat.busy && stat.out_free));

   // next-state logic
   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      k_in        = k_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (load_cnt_ff == LOAD_LAST) begin
                  load_cnt_in = '0;
                  state_in    = ST_CALC;
                  row_in      = '0;
                  col_in      = '0;
                  k_in        = '0;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
            end
         end
         ST_CALC: begin
            if (issue) begin
               if (last_k) begin
                  k_in = '0;
                  if (col_ff == IDX_LAST) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
                  if (last_entry) begin
                     state_in = ST_LOAD;
                  end
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         k_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         k_ff        <= k_in;
      end
   end

   // datapath control
   always_comb begin
      ctl.wr_en      = accept;
      ctl.wr_sel_b   = (load_cnt_ff >= LOAD_CELLS);
      ctl.wr_addr    = ctl.wr_sel_b ? CELL_AW'(load_cnt_ff - LOAD_CELLS)
                                    : CELL_AW'(load_cnt_ff);
      ctl.wr_data    = widen_element(req.element);
      ctl.issue      = issue;
      ctl.first      = (k_ff == '0);
      ctl.last_k     = last_k;
      ctl.last_entry = last_entry;
      ctl.row        = row_ff;
      ctl.col        = col_ff;
      ctl.a_k_addr   = cell_index(row_ff, k_ff);
      ctl.b_k_addr   = cell_index(k_ff, col_ff);
      ctl.rc_addr    = cell_index(row_ff, col_ff);
   end

   // load counter stays within one matrix pair
   `MXAM_ASSERT_IMPL(a_load_range, clock, reset, 1'b1, load_cnt_ff <= LOAD_LAST,
      "load counter out of range")
   // last element of a pair starts the computation at the first entry
   `MXAM_ASSERT_NEXT(a_calc_start, clock, reset, accept && load_cnt_ff == LOAD_LAST,
      state_ff == ST_CALC && row_ff == '0 && col_ff == '0 && k_ff == '0,
      "computation did not start after last element")
   // counter is back at zero whenever results are being computed
   `MXAM_ASSERT_IMPL(a_calc_count, clock, reset, state_ff == ST_CALC,
      load_cnt_ff == '0, "load counter not cleared during computation")
   // an entry starts only with the pipe drained and the result slot free
   `MXAM_ASSERT_IMPL(a_start_clear, clock, reset, issue && k_ff == '0,
      !stat.busy && stat.out_free, "entry started over a busy pipe")

endmodule

### sv/matrix3x3_add_multiply.sv
// ---------------------------------------------------------------------------
// matrix3x3_add_multiply
// Streaming 3x3 signed integer matrix add and multiply.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries one signed element per transfer: the nine elements of A
//   in row-major order, then the nine of B. Elements are taken at one per
//   cycle while loading.
//   After the eighteenth element, rsp_ch delivers nine result entries in
//   row-major order, each with row, column, A+B and the dot product of A's
//   row with B's column; last marks the ninth entry.
//   Each entry takes three steps of the shared multiply-accumulate unit,
//   and the next entry starts only once the read and multiply stages have drained.
//   req_ch.ready is low while the results are computed and rises again once
//   the last entry has been issued to the unit.
//   A stalled rsp_ch holds the waiting entry; the next entry is not started
//   until the result register is free, so nothing is lost.
//   Reset clears the load counter and the sequencer; the matrix stores are
//   not cleared, and their contents are used only after a full pair is loaded.
// ---------------------------------------------------------------------------
module matrix3x3_add_multiply (
   input  logic       clock,
   input  logic       reset,
   mxam_req_if.sink   req_ch,
   mxam_rsp_if.source rsp_ch
);
   import mxam_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   // load and step sequencer
   mxam_seq u_seq (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .stat  (stat),
      .ctl   (ctl)
   );

   // stores, shared MAC unit and result register
   mxam_dp u_dp (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .stat  (stat),
      .rsp   (rsp_ch)
   );

endmodule

### tb/matrix3x3_add_multiply_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// matrix3x3_add_multiply_tb
// Self-checking bench for the streaming 3x3 matrix add and multiply block.
// Elements are streamed in as A then B pairs. A local model keeps both
// matrices and, on the eighteenth element, queues the nine sum and product
// entries. Every result transfer is checked against the oldest queued entry.
// Both channels idle at random, and the result side is held off for a long
// stretch to fill the block.
// ---------------------------------------------------------------------------
module matrix3x3_add_multiply_tb;
   import mxam_pkg::*;

   localparam real CLK_PERIOD   = 12.0;
   localparam int  RESET_CYCLES = 3;
   localparam int  PAIR_ITEMS   = 2 * CELLS;
   localparam int  RANDOM_PAIRS = 6;
   localparam int  HOLD_CYCLES  = 200;
   localparam int  PAUSE_CYCLES = 30;
   localparam int  DRAIN_CYCLES = 40;
   localparam int  STALL_LIMIT  = 2000;

   // one expected result entry
   typedef struct packed {
      row_type  row;
      col_type  column;
      sum_type  sum_entry;
      prod_type product_entry;
      logic     last;
   } matrix_entry_type;

   logic clock = 1'b0;
   logic reset;

   mxam_req_if req_ch ();
   mxam_rsp_if rsp_ch ();

   matrix3x3_add_multiply DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // local copy of the loaded matrices and the load position
   elem_type         a_cells [CELLS];
   elem_type         b_cells [CELLS];
   int               elements_loaded = 0;
   matrix_entry_type expected_entries [$];

   int fail_count      = 0;
   bit req_gaps_on     = 1'b0;
   bit rsp_gaps_on     = 1'b0;
   int rsp_hold_cycles = 0;

   // clock
   always #(CLK_PERIOD / 2.0) clock = ~clock;

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(10, 40);
      end
   endfunction

   // element value: mostly full range, some corner values, some small ones
   function automatic element_type random_element();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return element_type'($urandom_range(0, 65535));
      end else if (roll < 85) begin
         case ($urandom_range(0, 4))
            0: return element_type'(-32768);
            1: return element_type'(32767);
            2: return element_type'(-1);
            3: return element_type'(1);
            default: return element_type'(0);
         endcase
      end else begin
         return element_type'($signed($urandom_range(0, 15)) - 8);
      end
   endfunction

   // queue the nine entries of the loaded pair
   task automatic queue_pair_results();
      matrix_entry_type entry;
      longint           dot;
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            dot = 0;
            for (int k = 0; k < DIM; k++) begin
               dot += longint'(a_cells[r*DIM + k]) * longint'(b_cells[k*DIM + c]);
            end
            entry.row           = row_type'(r);
            entry.column        = col_type'(c);
            entry.sum_entry     = sum_type'(longint'(a_cells[r*DIM + c]) +
                                            longint'(b_cells[r*DIM + c]));
            entry.product_entry = prod_type'(dot);
            entry.last          = (r == DIM - 1) && (c == DIM - 1);
            expected_entries.push_back(entry);
         end
      end
   endtask

   // store one accepted element, A first then B
   task automatic load_element(input element_type value);
      elem_type elem_value;
      elem_value = value[ELEM_WIDTH-1:0];
      if (elements_loaded < CELLS) begin
         a_cells[elements_loaded] = elem_value;
      end else begin
         b_cells[elements_loaded - CELLS] = elem_value;
      end
      elements_loaded++;
      if (elements_loaded == PAIR_ITEMS) begin
         queue_pair_results();
         elements_loaded = 0;
      end
   endtask

   // offer one element and wait for its transfer
   task automatic send_element(input element_type value);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.element <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      load_element(value);
   endtask

   task automatic send_random_pair();
      for (int i = 0; i < PAIR_ITEMS; i++) begin
         send_element(random_element());
      end
   endtask

   // stop offering until every queued entry has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      wait (expected_entries.size() == 0);
      @(posedge clock);
   endtask

   // corner values: most negative and most positive sums and products
   task automatic test_extreme_values();
      element_type a_vals [CELLS];
      element_type b_vals [CELLS];
      a_vals = '{-32768, -32768, -32768, 32767, 32767, 32767, 0, 1, -1};
      b_vals = '{-32768, 32767, 0, -32768, 32767, 1, -32768, 32767, -1};
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      for (int i = 0; i < CELLS; i++) send_element(a_vals[i]);
      for (int i = 0; i < CELLS; i++) send_element(b_vals[i]);
   endtask

   // random pairs, first without idling, then with idling on both sides
   task automatic test_random_pairs();
      for (int p = 0; p < RANDOM_PAIRS; p++) begin
         req_gaps_on = (p >= 2);
         rsp_gaps_on = (p >= 2);
         send_random_pair();
      end
   endtask

   // result side held off while elements keep coming, so the input stalls
   task automatic test_output_backpressure();
      req_gaps_on     = 1'b0;
      rsp_gaps_on     = 1'b1;
      rsp_hold_cycles = HOLD_CYCLES;
      send_random_pair();
      send_random_pair();
   endtask

   // sender stops partway into a pair until all results are in, then resumes
   task automatic test_pause_mid_pair();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      send_random_pair();
      for (int i = 0; i < 5; i++) send_element(random_element());
      wait_drained();
      repeat (PAUSE_CYCLES) @(posedge clock);
      for (int i = 5; i < PAIR_ITEMS; i++) send_element(random_element());
   endtask

   // result ready: long hold-off on request, else random stalls
   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_gaps_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // compare each result transfer with the oldest queued entry
   always @(posedge clock) begin : result_checker
      matrix_entry_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_entries.size() == 0) begin
            $error("result transfer with no entry queued: row %0d column %0d",
                   rsp_ch.row, rsp_ch.column);
            fail_count++;
         end else begin
            want = expected_entries.pop_front();
            if (rsp_ch.row !== want.row) begin
               $error("row: expected %0d, got %0d", want.row, rsp_ch.row);
               fail_count++;
            end
            if (rsp_ch.column !== want.column) begin
               $error("column: expected %0d, got %0d", want.column, rsp_ch.column);
               fail_count++;
            end
            if (rsp_ch.sum_entry !== want.sum_entry) begin
               $error("sum_entry: expected %0d, got %0d",
                      want.sum_entry, rsp_ch.sum_entry);
               fail_count++;
            end
            if (rsp_ch.product_entry !== want.product_entry) begin
               $error("product_entry: expected %0d, got %0d",
                      want.product_entry, rsp_ch.product_entry);
               fail_count++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
               fail_count++;
            end
         end
      end
   end

   // end the run when neither channel moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $error("no transfer for %0d cycles, %0d entries outstanding",
             STALL_LIMIT, expected_entries.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // test sequence
   initial begin : test_sequence
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.element <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_extreme_values();
      test_random_pairs();
      test_output_backpressure();
      test_pause_mid_pair();

      req_ch.valid <= 1'b0;
      wait (expected_entries.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
